// ===== sv/ethernet_tx_pad_and_fcs_assert.svh =====
// Assertion macros used by the checker file of the transmit pad/FCS block.
// Each macro expects signals named clock and reset in the including scope.
`ifndef ETHERNET_TX_PAD_AND_FCS_ASSERT_SVH
`define ETHERNET_TX_PAD_AND_FCS_ASSERT_SVH

// same-cycle implication
`define ETPF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("etpf assertion failed");

// next-cycle implication
`define ETPF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("etpf assertion failed");

`endif

// ===== sv/etpf_pkg.sv =====
// Package for the transmit pad/FCS block: frame limits, CRC constants, types.
// Used by every module of the block; depends on nothing.
package etpf_pkg;

   localparam int MAX_FRAME_BYTES = 1522;
   localparam int FCS_BYTES       = 4;
   localparam int STD_MIN_FRAME   = 60;
   localparam int DATA_LIMIT      = MAX_FRAME_BYTES - FCS_BYTES;
   localparam int COUNT_W         = $clog2(DATA_LIMIT + 1);
   localparam int FCS_IDX_W       = $clog2(FCS_BYTES);
   localparam int MIN_W           = 6;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   typedef enum logic {
      PH_DATA,
      PH_TAIL
   } phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_frame;
      logic       too_long;
   } rsp_item_type;

endpackage

// ===== sv/etpf_crc.sv =====
// Reflected CRC-32 byte fold (IEEE 802.3 polynomial), purely combinational.
// Depends on etpf_pkg for the polynomial.
module etpf_crc (
   input  logic [31:0] crc_cur,
   input  logic [7:0]  data,
   output logic [31:0] crc_next
);

   always_comb begin
      logic [31:0] c;
      c = crc_cur ^ {24'h0, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ etpf_pkg::CRC_POLY) : (c >> 1);
      end
      crc_next = c;
   end

endmodule

// ===== sv/etpf_seq.sv =====
// Frame sequencer: passes data bytes, appends zero pad and the FCS bytes,
// keeps the running CRC, byte count and overflow flag. Uses etpf_pkg, etpf_crc.
module etpf_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [5:0]              min_frame,
   input  logic                    in_valid,
   input  logic [7:0]              in_data,
   input  logic                    in_last,
   input  logic                    out_free,
   output logic                    consume,
   output logic                    emit,
   output etpf_pkg::rsp_item_type  item
);

   localparam logic [etpf_pkg::FCS_IDX_W-1:0] LAST_FCS =
      etpf_pkg::FCS_IDX_W'(etpf_pkg::FCS_BYTES - 1);

   etpf_pkg::phase_type                phase_ff, phase_in;
   logic [etpf_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [31:0]                        crc_ff, crc_in;
   logic                               overflow_ff, overflow_in;
   logic [etpf_pkg::FCS_IDX_W-1:0]     fcs_idx_ff, fcs_idx_in;

   logic [31:0]                        crc_next;
   logic [31:0]                        fcs;
   logic [7:0]                         fold_byte;
   logic [etpf_pkg::MIN_W-1:0]         min_len;

   // settings above the standard minimum act as the standard minimum
   assign min_len = (min_frame > etpf_pkg::MIN_W'(etpf_pkg::STD_MIN_FRAME)) ?
                    etpf_pkg::MIN_W'(etpf_pkg::STD_MIN_FRAME) : min_frame;

   assign fold_byte = (phase_ff == etpf_pkg::PH_DATA) ? in_data : 8'h00;
   assign fcs       = ~crc_ff;

   etpf_crc u_crc (
      .crc_cur  (crc_ff),
      .data     (fold_byte),
      .crc_next (crc_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= etpf_pkg::PH_DATA;
         count_ff    <= '0;
         crc_ff      <= etpf_pkg::CRC_INIT;
         overflow_ff <= 1'b0;
         fcs_idx_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         overflow_ff <= overflow_in;
         fcs_idx_ff  <= fcs_idx_in;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      overflow_in  = overflow_ff;
      fcs_idx_in   = fcs_idx_ff;
      consume      = 1'b0;
      emit         = 1'b0;
      item.out_byte     = in_data;
      item.end_of_frame = 1'b0;
      item.too_long     = 1'b0;

      unique case (phase_ff)
         etpf_pkg::PH_DATA: begin
            if (in_valid && out_free) begin
               consume = 1'b1;
               if (count_ff < etpf_pkg::COUNT_W'(etpf_pkg::DATA_LIMIT)) begin
                  emit     = 1'b1;
                  crc_in   = crc_next;
                  count_in = count_ff + 1'b1;
               end else begin
                  // frame too long: drop the byte
                  overflow_in = 1'b1;
               end
               if (in_last) begin
                  phase_in = etpf_pkg::PH_TAIL;
               end
            end
         end
         etpf_pkg::PH_TAIL: begin
            if (out_free) begin
               emit = 1'b1;
               if (count_ff < etpf_pkg::COUNT_W'(min_len)) begin
                  item.out_byte = 8'h00;
                  crc_in        = crc_next;
                  count_in      = count_ff + 1'b1;
               end else begin
                  item.out_byte = fcs[8*fcs_idx_ff +: 8];
                  fcs_idx_in    = fcs_idx_ff + 1'b1;
                  if (fcs_idx_ff == LAST_FCS) begin
                     item.end_of_frame = 1'b1;
                     item.too_long     = overflow_ff;
                     crc_in            = etpf_pkg::CRC_INIT;
                     count_in          = '0;
                     overflow_in       = 1'b0;
                     fcs_idx_in        = '0;
                     phase_in          = etpf_pkg::PH_DATA;
                  end
               end
            end
         end
         default: begin
            phase_in = etpf_pkg::PH_DATA;
         end
      endcase
   end

endmodule

// ===== sv/ethernet_tx_pad_and_fcs.sv =====
// Ethernet transmit pad and FCS generator, top level.
// Uses etpf_pkg and etpf_seq (which holds etpf_crc).
//
// Usage:
//   req_*  : frame bytes in order, req_last_byte on the final one; valid/ready.
//   rsp_*  : transmit bytes: data, zero pad up to the minimum length, then the
//            four FCS bytes least significant first; rsp_end_of_frame marks
//            the last FCS byte, rsp_too_long flags a truncated frame on it.
//   csr_*  : one register, min_frame_bytes (6 bits, values above 60 act as 60),
//            always ready; write it only between frames.
// Path: an accepted request enters the input register; the sequencer moves it
// into the output register, which drives rsp_valid, once that register is free.
// Throughput: one byte per cycle while the receiver does not stall. After the last
// byte the input is held off while the pad and the four FCS bytes go out, set by
// the single byte-wide CRC fold. Data bytes beyond 1518 are dropped.
// Reset: empties both registers, minimum back to 60, CRC to all ones, count 0.
// Receiver stall: the output register holds its byte; the sequencer and then
// the input register stop, and req_ready drops once the input register is full.
module ethernet_tx_pad_and_fcs (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_end_of_frame,
   output logic       rsp_too_long,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [5:0] csr_min_frame_bytes
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;
   logic [5:0]  min_frame_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   etpf_pkg::rsp_item_type rsp_item_ff;

   logic        out_free;
   logic        consume;
   logic        emit;
   logic        req_take;
   etpf_pkg::rsp_item_type seq_item;

   assign csr_ready   = 1'b1;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !in_valid_ff || consume;
   assign req_take    = req_valid && req_ready;
   assign in_valid_in = (in_valid_ff && !consume) || req_take;
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_frame_ff <= 6'(etpf_pkg::STD_MIN_FRAME);
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            min_frame_ff <= csr_min_frame_bytes;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (emit) begin
         rsp_item_ff <= seq_item;
      end
   end

   etpf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .min_frame (min_frame_ff),
      .in_valid  (in_valid_ff),
      .in_data   (in_data_ff),
      .in_last   (in_last_ff),
      .out_free  (out_free),
      .consume   (consume),
      .emit      (emit),
      .item      (seq_item)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_item_ff.out_byte;
   assign rsp_end_of_frame = rsp_item_ff.end_of_frame;
   assign rsp_too_long     = rsp_item_ff.too_long;

endmodule

// ===== sv/etpf_checker.sv =====
// Port-level checker for the transmit pad/FCS block, bound to the top level.
// Uses the macros of ethernet_tx_pad_and_fcs_assert.svh.
`include "ethernet_tx_pad_and_fcs_assert.svh"

module etpf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_data_byte,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_end_of_frame,
   input logic       rsp_too_long,
   input logic       csr_valid,
   input logic       csr_ready,
   input logic [5:0] csr_min_frame_bytes
);

   // responses accepted since the last end of frame, saturating
   logic [2:0] count_ff, count_in;
   logic       rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (rsp_take) begin
         if (rsp_end_of_frame) begin
            count_in = '0;
         end else if (count_ff != 3'd7) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `ETPF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_byte) && $stable(rsp_end_of_frame) &&
      $stable(rsp_too_long))
   `ETPF_ASSERT_IMPL(a_too_long_at_end, rsp_valid && rsp_too_long, rsp_end_of_frame)
   // at least one data byte and three FCS bytes come before the end mark
   `ETPF_ASSERT_IMPL(a_frame_min_bytes, rsp_take && rsp_end_of_frame, count_ff >= 3'd4)

endmodule

bind ethernet_tx_pad_and_fcs etpf_checker u_etpf_checker (.*);

// ===== tb/testbench.sv =====
// Testbench for ethernet_tx_pad_and_fcs. Frames go in byte by byte, and every
// transmitted byte is checked against a pad and CRC-32 FCS predictor.
// Depends on etpf_pkg and the RTL of the block only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int MAX_REPORTS    = 10;
   localparam int BYTES_PER_PASS = 20;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } frame_byte_type;

   logic       clock               = 1'b0;
   logic       reset               = 1'b1;
   logic       req_valid           = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte       = 8'h00;
   logic       req_last_byte       = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready           = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_end_of_frame;
   logic       rsp_too_long;
   logic       csr_valid           = 1'b0;
   logic       csr_ready;
   logic [5:0] csr_min_frame_bytes = 6'd0;

   ethernet_tx_pad_and_fcs u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_end_of_frame    (rsp_end_of_frame),
      .rsp_too_long        (rsp_too_long),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_min_frame_bytes (csr_min_frame_bytes)
   );

   always #HALF_PERIOD clock = ~clock;

   // predictor state
   logic [31:0]                  crc_run     = etpf_pkg::CRC_INIT;
   logic [etpf_pkg::COUNT_W-1:0] sent_count  = '0;
   logic                         dropped_any = 1'b0;
   logic [etpf_pkg::MIN_W-1:0]   min_len_reg =
      etpf_pkg::MIN_W'(etpf_pkg::STD_MIN_FRAME);

   frame_byte_type         frame_q[$];
   etpf_pkg::rsp_item_type tx_bytes_due[$];

   logic req_took      = 1'b0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic stall_arm     = 1'b0;
   logic stall_taken   = 1'b0;
   int   stall_left    = 0;
   int   quiet_cycles  = 0;
   int   mismatches    = 0;

   function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc,
                                                 input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++)
         c = c[0] ? ((c >> 1) ^ etpf_pkg::CRC_POLY) : (c >> 1);
      return c;
   endfunction

   task automatic predict_tx_bytes(input logic [7:0] data, input logic is_last);
      logic [etpf_pkg::MIN_W-1:0] pad_to;
      logic [31:0]                fcs;
      logic                       fcs_end;
      pad_to = (min_len_reg > etpf_pkg::STD_MIN_FRAME) ?
               etpf_pkg::MIN_W'(etpf_pkg::STD_MIN_FRAME) : min_len_reg;
      if (sent_count < etpf_pkg::DATA_LIMIT) begin
         tx_bytes_due.push_back({data, 1'b0, 1'b0});
         crc_run    = crc_fold_byte(crc_run, data);
         sent_count = sent_count + 1'b1;
      end else begin
         // past the size limit: dropped, no CRC
         dropped_any = 1'b1;
      end
      if (is_last) begin
         while (sent_count < pad_to) begin
            tx_bytes_due.push_back({8'h00, 1'b0, 1'b0});
            crc_run    = crc_fold_byte(crc_run, 8'h00);
            sent_count = sent_count + 1'b1;
         end
         fcs = ~crc_run;
         for (int i = 0; i < etpf_pkg::FCS_BYTES; i++) begin
            fcs_end = (i == etpf_pkg::FCS_BYTES - 1);
            tx_bytes_due.push_back({fcs[8*i +: 8], fcs_end, fcs_end & dropped_any});
         end
         crc_run     = etpf_pkg::CRC_INIT;
         sent_count  = '0;
         dropped_any = 1'b0;
      end
   endtask

   task automatic flag_bad_byte(input string why, input etpf_pkg::rsp_item_type want,
                                input etpf_pkg::rsp_item_type seen);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%s: expected byte %02h eof %0b too_long %0b, got %02h %0b %0b",
                  why, want.out_byte, want.end_of_frame, want.too_long,
                  seen.out_byte, seen.end_of_frame, seen.too_long);
   endtask

   // request driver
   always @(negedge clock) begin : driver
      frame_byte_type nxt;
      logic           nv;
      nv  = req_valid;
      nxt = {req_data_byte, req_last_byte};
      if (reset) begin
         nv = 1'b0;
      end else if (!req_valid || req_took) begin
         if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = frame_q.pop_front();
            nv  = 1'b1;
         end else begin
            nv = 1'b0;
         end
      end
      req_took = 1'b0;
      req_valid     <= nv;
      req_data_byte <= nxt.data_byte;
      req_last_byte <= nxt.last_byte;
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin : receiver
      logic nr;
      if (stall_arm && !stall_taken) begin
         stall_taken = 1'b1;
         stall_left  = LONG_HOLD;
      end
      if (stall_left > 0) begin
         stall_left--;
         nr = 1'b0;
      end else begin
         nr = ($urandom_range(99) >= recv_stall_pct);
      end
      rsp_ready <= nr;
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin : monitor
      etpf_pkg::rsp_item_type seen;
      etpf_pkg::rsp_item_type want;
      logic                   any_fire;
      if (!reset) begin
         any_fire = 1'b0;
         if (csr_valid && csr_ready) begin
            min_len_reg = csr_min_frame_bytes;
            any_fire    = 1'b1;
         end
         if (req_valid && req_ready) begin
            predict_tx_bytes(req_data_byte, req_last_byte);
            req_took = 1'b1;
            any_fire = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            any_fire = 1'b1;
            seen = {rsp_out_byte, rsp_end_of_frame, rsp_too_long};
            if (tx_bytes_due.size() == 0) begin
               flag_bad_byte("unexpected byte", '0, seen);
            end else begin
               want = tx_bytes_due.pop_front();
               if (seen !== want)
                  flag_bad_byte("wrong byte", want, seen);
            end
         end
         if (any_fire)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic queue_byte(input logic [7:0] data, input logic is_last);
      frame_q.push_back({data, is_last});
   endtask

   task automatic queue_frame(input int len);
      for (int i = 1; i <= len; i++)
         frame_q.push_back({8'($urandom), 1'(i == len)});
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 70)
         return $urandom_range(20, 1);
      else if (r < 90)
         return $urandom_range(64, 21);
      else
         return $urandom_range(100, 65);
   endfunction

   function automatic logic [etpf_pkg::MIN_W-1:0] pick_min();
      case ($urandom_range(3))
         0: return '0;
         1: return etpf_pkg::MIN_W'(etpf_pkg::STD_MIN_FRAME);
         2: return '1;
         default: return etpf_pkg::MIN_W'($urandom);
      endcase
   endfunction

   // wait until every request is in and every byte is out
   task automatic drain_frames();
      do @(posedge clock);
      while (frame_q.size() != 0 || req_valid || tx_bytes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [etpf_pkg::MIN_W-1:0] value);
      @(negedge clock);
      csr_valid           <= 1'b1;
      csr_min_frame_bytes <= value;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int queued;
      int len;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset minimum: short frames padded to 60
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hA5, 1'b0);
      queue_byte(8'h5A, 1'b0);
      queue_byte(8'h3C, 1'b1);
      drain_frames();

      // zero minimum: no pad at all
      csr_write('0);
      queue_byte(8'h80, 1'b1);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h7E, 1'b1);
      drain_frames();

      // above 60 behaves as 60
      csr_write('1);
      queue_byte(8'h55, 1'b1);
      queue_frame(61);
      drain_frames();

      // frame exactly at the minimum, and one byte short of it
      csr_write(etpf_pkg::MIN_W'(2));
      queue_frame(2);
      queue_frame(1);
      drain_frames();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 52;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 52;
            end
            default: begin
               send_idle_pct  = 28;
               recv_stall_pct = 28;
            end
         endcase
         csr_write(pick_min());
         queued = 0;
         while (queued < BYTES_PER_PASS) begin
            len = pick_length();
            queue_frame(len);
            queued += len;
         end
         drain_frames();
      end

      // long receiver hold-off with the sender flat out, so the input backs up
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      csr_write(etpf_pkg::MIN_W'(etpf_pkg::STD_MIN_FRAME));
      stall_arm = 1'b1;
      queue_frame(30);
      queue_frame(3);
      queue_frame(30);
      drain_frames();

      mismatches += tx_bytes_due.size();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
